>>> src/smsr_pkg.sv
package smsr_pkg;

	// Default sizes of the node store and of the element numbering.
	localparam int NODE_COUNT_DEF = 1024;
	localparam int ELEM_BITS_DEF  = 16;

	// Fixed field widths of the request and response.
	localparam int IDX_W  = 10;
	localparam int SIGN_W = 8;
	localparam int ENUM_W = 16;
	localparam int NNUM_W = 11;

	// Node numbering saturates at the top of its field.
	localparam logic [NNUM_W-1:0] NODE_NUMBER_MAX = {NNUM_W{1'b1}};

	// Corner sequencing covers four corners per element.
	localparam logic [1:0] CORNER_LAST = 2'd3;

	// Mode register codes.
	localparam logic MODE_EMBEDDED = 1'b0;

	// Location codes that select a tetrahedron in each mode.
	localparam logic [SIGN_W-1:0] SIGN_EMB_POS  = 8'h01;
	localparam logic [SIGN_W-1:0] SIGN_EMB_NEG  = 8'hFB;
	localparam logic [SIGN_W-1:0] SIGN_BODY_ZERO = 8'h00;
	localparam logic [SIGN_W-1:0] SIGN_BODY_NEG  = 8'hFF;

	typedef enum logic [1:0] {
		OP_SET_SIGN  = 2'd0,
		OP_ADD_ELEM  = 2'd1,
		OP_NEXT_NODE = 2'd2,
		OP_CLEAR     = 2'd3
	} op_t;

	typedef struct packed {
		op_t                      operation;
		logic [IDX_W-1:0]         node_index;
		logic signed [SIGN_W-1:0] node_sign;
		logic [IDX_W-1:0]         corner_a;
		logic [IDX_W-1:0]         corner_b;
		logic [IDX_W-1:0]         corner_c;
		logic [IDX_W-1:0]         corner_d;
	} req_t;

	typedef struct packed {
		logic              element_kept;
		logic [ENUM_W-1:0] element_number;
		logic [IDX_W-1:0]  node_out_index;
		logic [NNUM_W-1:0] node_renum;
		logic              last_node;
	} rsp_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic       capture;
		logic       sign_wr;
		logic       sign_rd;
		logic       mark_wr;
		logic [1:0] sel;
		logic       sweep;
		logic       walk_rd;
		logic       load;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		op_t  req_op;
		logic kept;
		logic sweep_last;
		logic out_free;
	} status_t;

	// True when a location code selects its tetrahedron in the given mode.
	function automatic logic sign_selects(input logic mode, input logic [SIGN_W-1:0] s);
		logic hit;
		if (mode == MODE_EMBEDDED) begin
			hit = (s == SIGN_EMB_POS) || (s == SIGN_EMB_NEG);
		end else begin
			hit = (s == SIGN_BODY_ZERO) || (s == SIGN_BODY_NEG);
		end
		return hit;
	endfunction

endpackage

>>> src/smsr_ram.sv
module smsr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// One write port and one registered read port; read data holds between reads.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

>>> src/smsr_ctrl.sv
module smsr_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_ready,
	input  smsr_pkg::status_t status,
	output smsr_pkg::cmd_t    cmd
);

	import smsr_pkg::*;

	typedef enum logic [3:0] {
		ST_SWEEP,
		ST_IDLE,
		ST_SIGN_WR,
		ST_ELEM_RD,
		ST_ELEM_CHK,
		ST_ELEM_MARK,
		ST_WALK_RD,
		ST_DONE
	} state_t;

	state_t     state_q;
	logic [1:0] sel_q;
	logic       clr_rsp_q;

	// Sequencer: the mark store is swept after reset before any request is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_SWEEP;
			sel_q     <= 2'd0;
			clr_rsp_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_SWEEP: begin
					if (status.sweep_last) begin
						state_q <= clr_rsp_q ? ST_DONE : ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (req_valid) begin
						sel_q <= 2'd0;
						unique case (status.req_op)
							OP_SET_SIGN:  state_q <= ST_SIGN_WR;
							OP_ADD_ELEM:  state_q <= ST_ELEM_RD;
							OP_NEXT_NODE: state_q <= ST_WALK_RD;
							OP_CLEAR: begin
								state_q   <= ST_SWEEP;
								clr_rsp_q <= 1'b1;
							end
						endcase
					end
				end
				ST_SIGN_WR: begin
					state_q <= ST_DONE;
				end
				ST_ELEM_RD: begin
					sel_q <= sel_q + 2'd1;
					if (sel_q == CORNER_LAST) begin
						state_q <= ST_ELEM_CHK;
					end
				end
				ST_ELEM_CHK: begin
					state_q <= status.kept ? ST_ELEM_MARK : ST_DONE;
				end
				ST_ELEM_MARK: begin
					sel_q <= sel_q + 2'd1;
					if (sel_q == CORNER_LAST) begin
						state_q <= ST_DONE;
					end
				end
				ST_WALK_RD: begin
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (status.out_free) begin
						state_q   <= ST_IDLE;
						clr_rsp_q <= 1'b0;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Command decode from the current state.
	always_comb begin
		cmd         = '0;
		cmd.capture = (state_q == ST_IDLE) && req_valid;
		cmd.sign_wr = (state_q == ST_SIGN_WR);
		cmd.sign_rd = (state_q == ST_ELEM_RD);
		cmd.mark_wr = (state_q == ST_ELEM_MARK);
		cmd.sel     = sel_q;
		cmd.sweep   = (state_q == ST_SWEEP);
		cmd.walk_rd = (state_q == ST_WALK_RD);
		cmd.load    = (state_q == ST_DONE) && status.out_free;
	end

	assign req_ready = (state_q == ST_IDLE);

endmodule

>>> src/smsr_dp.sv
module smsr_dp #(
	parameter int NODE_COUNT          = smsr_pkg::NODE_COUNT_DEF,
	parameter int ELEMENT_NUMBER_BITS = smsr_pkg::ELEM_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  smsr_pkg::req_t    req,
	output smsr_pkg::rsp_t    rsp,
	output logic              rsp_valid,
	input  logic              rsp_ready,
	input  logic              mode_we,
	input  logic              mode_wdata,
	input  smsr_pkg::cmd_t    cmd,
	output smsr_pkg::status_t status
);

	import smsr_pkg::*;

	localparam int NIW = $clog2(NODE_COUNT);
	localparam int EB  = ELEMENT_NUMBER_BITS;
	localparam logic [EB-1:0]  ELEM_MAX  = {EB{1'b1}};
	localparam logic [NIW-1:0] NODE_LAST = NIW'(NODE_COUNT - 1);

	req_t             item_q;
	rsp_t             rsp_q;
	logic             rsp_valid_q;
	logic             mode_q;
	logic             hit_q;
	logic             chk_pend_q;
	logic [1:0]       chk_sel_q;
	logic [NIW-1:0]   sweep_addr_q;
	logic [NIW-1:0]   cursor_q;
	logic [EB-1:0]    elem_cnt_q;
	logic [NNUM_W-1:0] node_cnt_q;

	logic [IDX_W-1:0]  corner [4];
	logic [3:0]        corner_ok;
	logic [IDX_W-1:0]  corner_sel;
	logic [SIGN_W-1:0] sign_rdata;
	logic              mark_rdata;
	logic              kept_now;
	logic              node_ok;

	logic              mark_we;
	logic [NIW-1:0]    mark_waddr;
	logic              mark_wdata;

	rsp_t              rsp_next;
	logic [EB-1:0]     elem_next;
	logic [NNUM_W-1:0] node_next;
	logic [NIW-1:0]    cursor_next;

	// An index is usable only when it lies inside the node store.
	function automatic logic idx_ok(input logic [IDX_W-1:0] v);
		return 32'(v) < 32'(NODE_COUNT);
	endfunction

	// Latch the request at its transfer and the response at its load; the payload needs no reset.
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			item_q <= req;
		end
		if (cmd.load) begin
			rsp_q <= rsp_next;
		end
		chk_sel_q <= cmd.sel;
	end

	// Corner selection for the one-per-cycle store accesses.
	always_comb begin
		corner[0] = item_q.corner_a;
		corner[1] = item_q.corner_b;
		corner[2] = item_q.corner_c;
		corner[3] = item_q.corner_d;
		for (int k = 0; k < 4; k++) begin
			corner_ok[k] = idx_ok(corner[k]);
		end
		corner_sel = corner[cmd.sel];
		node_ok    = idx_ok(item_q.node_index);
	end

	smsr_ram #(
		.WIDTH(SIGN_W),
		.DEPTH(NODE_COUNT)
	) u_sign_ram (
		.clk  (clk),
		.we   (cmd.sign_wr && node_ok),
		.waddr(NIW'(item_q.node_index)),
		.wdata(item_q.node_sign),
		.re   (cmd.sign_rd),
		.raddr(NIW'(corner_sel)),
		.rdata(sign_rdata)
	);

	// Mark writes come from the clearing sweep or from a kept element.
	always_comb begin
		if (cmd.sweep) begin
			mark_we    = 1'b1;
			mark_waddr = sweep_addr_q;
			mark_wdata = 1'b0;
		end else begin
			mark_we    = cmd.mark_wr && corner_ok[cmd.sel];
			mark_waddr = NIW'(corner_sel);
			mark_wdata = 1'b1;
		end
	end

	smsr_ram #(
		.WIDTH(1),
		.DEPTH(NODE_COUNT)
	) u_mark_ram (
		.clk  (clk),
		.we   (mark_we),
		.waddr(mark_waddr),
		.wdata(mark_wdata),
		.re   (cmd.walk_rd),
		.raddr(cursor_q),
		.rdata(mark_rdata)
	);

	// The sign read issued last cycle is checked against the mode here.
	assign kept_now = hit_q || (chk_pend_q && corner_ok[chk_sel_q] &&
		sign_selects(mode_q, sign_rdata));

	// Result of the finished request and the counter updates that go with it.
	always_comb begin
		rsp_next    = '0;
		elem_next   = elem_cnt_q;
		node_next   = node_cnt_q;
		cursor_next = cursor_q;
		unique case (item_q.operation)
			OP_ADD_ELEM: begin
				if (hit_q) begin
					elem_next = (elem_cnt_q == ELEM_MAX) ? elem_cnt_q : elem_cnt_q + EB'(1);
					rsp_next.element_kept   = 1'b1;
					rsp_next.element_number = ENUM_W'(elem_next);
				end
			end
			OP_NEXT_NODE: begin
				rsp_next.node_out_index = IDX_W'(cursor_q);
				if (mark_rdata) begin
					node_next = (node_cnt_q == NODE_NUMBER_MAX) ? node_cnt_q :
						node_cnt_q + NNUM_W'(1);
					rsp_next.node_renum = node_next;
				end
				if (cursor_q == NODE_LAST) begin
					rsp_next.last_node = 1'b1;
					cursor_next        = '0;
					node_next          = '0;
				end else begin
					cursor_next = cursor_q + NIW'(1);
				end
			end
			OP_SET_SIGN, OP_CLEAR: begin
			end
		endcase
	end

	// Control state, counters and the output register flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q  <= 1'b0;
			mode_q       <= MODE_EMBEDDED;
			hit_q        <= 1'b0;
			chk_pend_q   <= 1'b0;
			sweep_addr_q <= '0;
			cursor_q     <= '0;
			elem_cnt_q   <= '0;
			node_cnt_q   <= '0;
		end else begin
			if (mode_we) begin
				mode_q <= mode_wdata;
			end
			chk_pend_q <= cmd.sign_rd;
			if (cmd.capture) begin
				hit_q <= 1'b0;
			end else if (chk_pend_q) begin
				hit_q <= kept_now;
			end
			if (cmd.sweep) begin
				sweep_addr_q <= (sweep_addr_q == NODE_LAST) ? '0 : sweep_addr_q + NIW'(1);
				cursor_q     <= '0;
				elem_cnt_q   <= '0;
				node_cnt_q   <= '0;
			end else if (cmd.load) begin
				cursor_q   <= cursor_next;
				elem_cnt_q <= elem_next;
				node_cnt_q <= node_next;
			end
			if (cmd.load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		status.req_op     = req.operation;
		status.kept       = kept_now;
		status.sweep_last = (sweep_addr_q == NODE_LAST);
		status.out_free   = !rsp_valid_q || rsp_ready;
	end

	assign rsp       = rsp_q;
	assign rsp_valid = rsp_valid_q;

endmodule

>>> src/submesh_select_and_renumber.sv
// A sign write or a node step makes a single store access before its response is loaded;
// an element is checked after its sign reads and marked only if kept; clear sweeps the mark store.
// An element reads four signs and, if kept, then writes four marks, one store access per cycle.
// Ready returns in the cycle after the response is loaded, so one request is in work at a time.
// Reset is asynchronous, active low; afterwards the mark store is cleared node by node
// before the first request is taken (mode writes are taken at once).
module submesh_select_and_renumber #(
	parameter int NODE_COUNT          = smsr_pkg::NODE_COUNT_DEF,
	parameter int ELEMENT_NUMBER_BITS = smsr_pkg::ELEM_BITS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_ready,
	input  smsr_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_ready,
	output smsr_pkg::rsp_t rsp,
	input  logic           mode_we,
	input  logic           mode_wdata
);

	import smsr_pkg::*;

	cmd_t    cmd;
	status_t status;

	// Sequencer for the store accesses of each request.
	smsr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.status   (status),
		.cmd      (cmd)
	);

	// Stores, counters and the response register.
	smsr_dp #(
		.NODE_COUNT         (NODE_COUNT),
		.ELEMENT_NUMBER_BITS(ELEMENT_NUMBER_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.rsp       (rsp),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.mode_we   (mode_we),
		.mode_wdata(mode_wdata),
		.cmd       (cmd),
		.status    (status)
	);

endmodule

>>> src/smsr_checker.sv
module smsr_checker #(
	parameter int NODE_COUNT = smsr_pkg::NODE_COUNT_DEF
) (
	input logic           clk,
	input logic           arst_n,
	input logic           req_valid,
	input logic           req_ready,
	input smsr_pkg::req_t req,
	input logic           rsp_valid,
	input logic           rsp_ready,
	input smsr_pkg::rsp_t rsp
);

	import smsr_pkg::*;

	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NODE_COUNT - 1);

	// A stalled response holds its value.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("response changed while stalled");

	// One request at a time: ready drops right after a request transfer.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request taken while another is in work");

	// The end of a node walk is flagged only for the highest node index.
	a_last_index: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.last_node |-> rsp.node_out_index == LAST_IDX)
		else $error("end of walk flagged at the wrong node");

	// A dropped or non-element response carries no element number.
	a_elem_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp.element_kept |-> rsp.element_number == '0)
		else $error("element number without a kept element");

	// Element and node results never share one response.
	a_fields_apart: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.element_kept |-> rsp.node_renum == '0 && !rsp.last_node)
		else $error("element and node results mixed");

endmodule

bind submesh_select_and_renumber smsr_checker #(.NODE_COUNT(NODE_COUNT)) u_smsr_checker (.*);
